### hdl/vna_pkg.sv
package vna_pkg;

  // Sizing of the stores and of the number formats
  localparam int VERTEX_SLOTS = 1024;
  localparam int ACCUM_W      = 24;
  localparam int COORD_W      = 16;
  localparam int ADDR_W       = $clog2(VERTEX_SLOTS);

  // Port field widths
  localparam int SLOT_W = 10;
  localparam int FIX_W  = 16;

  // Datapath widths
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int NORM_TOP  = 30;
  localparam int NORM_FRAC = 14;
  localparam int NIN_A     = (CROSS_W > ACCUM_W) ? CROSS_W : ACCUM_W;
  localparam int NIN_W     = (NIN_A > NORM_TOP) ? NIN_A : NORM_TOP + 1;
  localparam int SQ_W      = 2 * NORM_TOP + 2;
  localparam int ROOT_W    = NORM_TOP + 1;
  localparam int Q_W       = NORM_FRAC + 1;
  localparam int NUM_W     = NORM_TOP + NORM_FRAC + 1;

  localparam int POS_RAM_W = 3 * COORD_W;
  localparam int ACC_RAM_W = 3 * ACCUM_W;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [FIX_W-1:0] pos_x;
    logic signed [FIX_W-1:0] pos_y;
    logic signed [FIX_W-1:0] pos_z;
    logic [SLOT_W-1:0]       corner_a;
    logic [SLOT_W-1:0]       corner_b;
    logic [SLOT_W-1:0]       corner_c;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       vertex_slot;
    logic signed [FIX_W-1:0] normal_x;
    logic signed [FIX_W-1:0] normal_y;
    logic signed [FIX_W-1:0] normal_z;
    logic                    normal_valid;
  } out_item_t;

  // Status from the normalise unit
  typedef struct packed {
    logic done;
    logic nonzero;
  } norm_stat_t;

  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));

  // Clamp an input coordinate into the stored coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [FIX_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi > COORD_MAX) begin
      vi = COORD_MAX;
    end else if (vi < COORD_MIN) begin
      vi = COORD_MIN;
    end
    return COORD_W'(vi);
  endfunction

  // Saturating accumulator add
  function automatic logic signed [ACCUM_W-1:0] acc_sat(logic signed [ACCUM_W-1:0] a,
                                                        logic signed [FIX_W-1:0] b);
    logic signed [ACCUM_W:0] s;
    s = (ACCUM_W+1)'(a) + (ACCUM_W+1)'(b);
    if (s[ACCUM_W] != s[ACCUM_W-1]) begin
      return s[ACCUM_W] ? {1'b1, {(ACCUM_W-1){1'b0}}} : {1'b0, {(ACCUM_W-1){1'b1}}};
    end
    return s[ACCUM_W-1:0];
  endfunction

endpackage

### hdl/vna_ram.sv
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### hdl/vna_cross.sv
module vna_cross (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [vna_pkg::COORD_W-1:0] pa_i [3],
  input  logic signed [vna_pkg::COORD_W-1:0] pb_i [3],
  input  logic signed [vna_pkg::COORD_W-1:0] pc_i [3],
  output logic signed [vna_pkg::CROSS_W-1:0] cr_o [3],
  output logic                               done_o
);

  logic signed [vna_pkg::EDGE_W-1:0]  e1_q [3];
  logic signed [vna_pkg::EDGE_W-1:0]  e2_q [3];
  logic signed [vna_pkg::PROD_W-1:0]  prod_q;
  logic signed [vna_pkg::CROSS_W-1:0] cr_q [3];
  logic [2:0]                         cnt_q;
  logic                               busy_q;
  logic                               done_q;
  logic signed [vna_pkg::EDGE_W-1:0]  opa, opb;
  logic [2:0]                         k;
  logic [1:0]                         lane;

  // Operand select for the six partial products
  always_comb begin
    opa = e1_q[1];
    opb = e2_q[2];
    unique case (cnt_q)
      3'd0:    begin opa = e1_q[1]; opb = e2_q[2]; end
      3'd1:    begin opa = e1_q[2]; opb = e2_q[1]; end
      3'd2:    begin opa = e1_q[2]; opb = e2_q[0]; end
      3'd3:    begin opa = e1_q[0]; opb = e2_q[2]; end
      3'd4:    begin opa = e1_q[0]; opb = e2_q[1]; end
      3'd5:    begin opa = e1_q[1]; opb = e2_q[0]; end
      default: begin opa = e1_q[1]; opb = e2_q[2]; end
    endcase
  end

  assign k    = cnt_q - 3'd1;
  assign lane = k[2:1];

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 3'd6) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  // Edges, one shared multiplier, accumulate into the cross terms
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= vna_pkg::EDGE_W'(pb_i[i]) - vna_pkg::EDGE_W'(pa_i[i]);
        e2_q[i] <= vna_pkg::EDGE_W'(pc_i[i]) - vna_pkg::EDGE_W'(pa_i[i]);
      end
    end else if (busy_q) begin
      if (cnt_q != 3'd6) begin
        prod_q <= opa * opb;
      end
      if (cnt_q != 3'd0) begin
        if (!k[0]) begin
          cr_q[lane] <= vna_pkg::CROSS_W'(prod_q);
        end else begin
          cr_q[lane] <= cr_q[lane] - vna_pkg::CROSS_W'(prod_q);
        end
      end
    end
  end

  assign cr_o   = cr_q;
  assign done_o = done_q;

endmodule

### hdl/vna_norm.sv
module vna_norm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [vna_pkg::NIN_W-1:0] vec_i [3],
  output logic signed [vna_pkg::FIX_W-1:0] unit_o [3],
  output vna_pkg::norm_stat_t              stat_o
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_DONE  = 3'd5;

  localparam int CNT_W = $clog2(vna_pkg::Q_W);

  logic [2:0]                        st_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic                              nz_q;
  logic [vna_pkg::NIN_W-1:0]         m_q [3];
  logic                              neg_q [3];
  logic [2*vna_pkg::NORM_TOP-1:0]    prod_q;
  logic [vna_pkg::SQ_W-1:0]          sum_q, rn_q, root_q, bit_q;
  logic [vna_pkg::NUM_W-1:0]         d_q;
  logic [vna_pkg::NUM_W-1:0]         rem_q [3];
  logic [vna_pkg::Q_W-1:0]           qt_q [3];

  logic [vna_pkg::NIN_W-1:0]         mag [3];
  logic [vna_pkg::NIN_W-1:0]         or_m;
  logic [vna_pkg::NORM_TOP-1:0]      m30 [3];
  logic [vna_pkg::SQ_W-1:0]          trial, rn_nx, root_nx;
  logic [vna_pkg::ROOT_W-1:0]        len;
  logic [1:0]                        sq_idx;

  // Magnitudes of the incoming vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][vna_pkg::NIN_W-1] ? (~vec_i[i] + vna_pkg::NIN_W'(1)) : vec_i[i];
      m30[i] = m_q[i][vna_pkg::NORM_TOP-1:0];
    end
    or_m = m_q[0] | m_q[1] | m_q[2];
  end

  // One step of the bit-pair square root
  always_comb begin
    trial   = root_q + bit_q;
    rn_nx   = rn_q;
    root_nx = root_q >> 1;
    if (rn_q >= trial) begin
      rn_nx   = rn_q - trial;
      root_nx = (root_q >> 1) + bit_q;
    end
    len = root_nx[vna_pkg::ROOT_W-1:0];
  end

  assign sq_idx = cnt_q[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= N_IDLE;
      cnt_q <= '0;
      nz_q  <= 1'b0;
    end else begin
      unique case (st_q)
        N_IDLE: begin
          if (start_i) begin
            cnt_q <= '0;
            if ((mag[0] | mag[1] | mag[2]) == '0) begin
              nz_q <= 1'b0;
              st_q <= N_DONE;
            end else begin
              nz_q <= 1'b1;
              st_q <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (!(|or_m[vna_pkg::NIN_W-1:vna_pkg::NORM_TOP]) &&
              or_m[vna_pkg::NORM_TOP-1]) begin
            st_q <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_q == CNT_W'(3)) begin
            st_q <= N_SQRT;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        N_SQRT: begin
          if (bit_q[0]) begin
            cnt_q <= '0;
            st_q  <= N_DIV;
          end
        end
        N_DIV: begin
          if (cnt_q == CNT_W'(vna_pkg::Q_W - 1)) begin
            st_q <= N_DONE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        N_DONE:  st_q <= N_IDLE;
        default: st_q <= N_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            m_q[i]   <= mag[i];
            neg_q[i] <= vec_i[i][vna_pkg::NIN_W-1];
            qt_q[i]  <= '0;
          end
          sum_q <= '0;
        end
      end
      N_SHIFT: begin
        // shift all three together until the largest has exactly NORM_TOP bits
        for (int i = 0; i < 3; i++) begin
          if (|or_m[vna_pkg::NIN_W-1:vna_pkg::NORM_TOP]) begin
            m_q[i] <= m_q[i] >> 1;
          end else if (!or_m[vna_pkg::NORM_TOP-1]) begin
            m_q[i] <= m_q[i] << 1;
          end
        end
      end
      N_SQ: begin
        if (cnt_q != CNT_W'(3)) begin
          prod_q <= m30[sq_idx] * m30[sq_idx];
        end
        if (cnt_q != '0) begin
          sum_q <= sum_q + vna_pkg::SQ_W'(prod_q);
        end
        if (cnt_q == CNT_W'(3)) begin
          rn_q   <= sum_q + vna_pkg::SQ_W'(prod_q);
          root_q <= '0;
          bit_q  <= vna_pkg::SQ_W'(1) << (vna_pkg::SQ_W - 2);
        end
      end
      N_SQRT: begin
        rn_q   <= rn_nx;
        root_q <= root_nx;
        bit_q  <= bit_q >> 2;
        if (bit_q[0]) begin
          d_q <= vna_pkg::NUM_W'(len) << vna_pkg::NORM_FRAC;
          for (int i = 0; i < 3; i++) begin
            rem_q[i] <= (vna_pkg::NUM_W'(m30[i]) << vna_pkg::NORM_FRAC) +
                        vna_pkg::NUM_W'(len >> 1);
          end
        end
      end
      N_DIV: begin
        // restoring division, three lanes side by side
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= d_q) begin
            rem_q[i] <= rem_q[i] - d_q;
            qt_q[i]  <= {qt_q[i][vna_pkg::Q_W-2:0], 1'b1};
          end else begin
            qt_q[i]  <= {qt_q[i][vna_pkg::Q_W-2:0], 1'b0};
          end
        end
        d_q <= d_q >> 1;
      end
      N_DONE: ;
      default: ;
    endcase
  end

  // Signed result
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = neg_q[i] ? -$signed({1'b0, qt_q[i]}) : $signed({1'b0, qt_q[i]});
    end
    stat_o.done    = (st_q == N_DONE);
    stat_o.nonzero = nz_q;
  end

endmodule

### hdl/vertex_normal_accumulator.sv
// Smooth vertex normal accumulator. Items are taken one at a time. A load
// to an in-range slot writes the position and clears the slot's sums in the
// cycle it transfers; the next item may follow at once. A triangle holds the
// input off after its transfer, through three position reads, the shared
// cross-product multiplier, the normalise unit (alignment shifting, the sum
// of squares, the square root, the division and a finishing step) and the
// read-modify-write of each corner in the single-ported accumulator memory.
// A degenerate triangle skips the normalise steps. A query runs through the
// same normalise unit, which a zero sum skips, and may wait for the output
// register to drain. There is no clearing pass after reset; slots must be
// loaded before use.
module vertex_normal_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vna_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vna_pkg::out_item_t out_data_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TRD_B  = 4'd1;
  localparam logic [3:0] ST_TRD_C  = 4'd2;
  localparam logic [3:0] ST_TCAP   = 4'd3;
  localparam logic [3:0] ST_CROSS  = 4'd4;
  localparam logic [3:0] ST_TNORM  = 4'd5;
  localparam logic [3:0] ST_ACC_RD = 4'd6;
  localparam logic [3:0] ST_ACC_WR = 4'd7;
  localparam logic [3:0] ST_QRD    = 4'd8;
  localparam logic [3:0] ST_QNORM  = 4'd9;
  localparam logic [3:0] ST_QOUT   = 4'd10;

  localparam int CW = vna_pkg::COORD_W;
  localparam int AW = vna_pkg::ACCUM_W;

  logic [3:0]                 state_q;
  vna_pkg::in_item_t          item_q;
  logic [1:0]                 cidx_q;
  logic                       qin_q;
  vna_pkg::out_item_t         out_q;
  logic                       out_valid_q;
  logic signed [CW-1:0]       pa_q [3];
  logic signed [CW-1:0]       pb_q [3];

  logic                       accept;
  logic                       a_ok, b_ok, c_ok, ia_ok;
  logic                       pos_we, acc_we;
  logic [vna_pkg::ADDR_W-1:0] pos_addr, acc_addr;
  logic [vna_pkg::POS_RAM_W-1:0] pos_wdata, pos_rdata;
  logic [vna_pkg::ACC_RAM_W-1:0] acc_wdata, acc_rdata;
  logic signed [CW-1:0]       pc [3];
  logic signed [AW-1:0]       acc_old [3];
  logic [vna_pkg::SLOT_W-1:0] corner;

  logic                       cross_start, cross_done;
  logic signed [vna_pkg::CROSS_W-1:0] cr [3];
  logic                       norm_start;
  logic signed [vna_pkg::NIN_W-1:0]   norm_vec [3];
  logic signed [vna_pkg::FIX_W-1:0]   unit [3];
  vna_pkg::norm_stat_t        nstat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Slot range checks
  assign ia_ok = 32'(in_data_i.corner_a) < vna_pkg::VERTEX_SLOTS;
  assign a_ok  = 32'(item_q.corner_a) < vna_pkg::VERTEX_SLOTS;
  assign b_ok  = 32'(item_q.corner_b) < vna_pkg::VERTEX_SLOTS;
  assign c_ok  = 32'(item_q.corner_c) < vna_pkg::VERTEX_SLOTS;

  // Corner under read-modify-write
  always_comb begin
    unique case (cidx_q)
      2'd0:    corner = item_q.corner_a;
      2'd1:    corner = item_q.corner_b;
      default: corner = item_q.corner_c;
    endcase
  end

  // Unpack memory words
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pc[i]      = $signed(pos_rdata[vna_pkg::POS_RAM_W-1-i*CW -: CW]);
      acc_old[i] = $signed(acc_rdata[vna_pkg::ACC_RAM_W-1-i*AW -: AW]);
    end
  end

  // Position memory port
  always_comb begin
    pos_we    = accept && (in_data_i.operation == vna_pkg::OP_LOAD) && ia_ok;
    pos_wdata = {vna_pkg::sat_coord(in_data_i.pos_x), vna_pkg::sat_coord(in_data_i.pos_y),
                 vna_pkg::sat_coord(in_data_i.pos_z)};
    unique case (state_q)
      ST_TRD_B: pos_addr = vna_pkg::ADDR_W'(item_q.corner_b);
      ST_TRD_C: pos_addr = vna_pkg::ADDR_W'(item_q.corner_c);
      default:  pos_addr = vna_pkg::ADDR_W'(in_data_i.corner_a);
    endcase
  end

  // Accumulator memory port: clear on load, saturating add per corner
  always_comb begin
    if (state_q == ST_ACC_WR) begin
      acc_we    = 1'b1;
      acc_wdata = {vna_pkg::acc_sat(acc_old[0], unit[0]),
                   vna_pkg::acc_sat(acc_old[1], unit[1]),
                   vna_pkg::acc_sat(acc_old[2], unit[2])};
    end else begin
      acc_we    = pos_we;
      acc_wdata = '0;
    end
    if (state_q == ST_ACC_RD || state_q == ST_ACC_WR) begin
      acc_addr = vna_pkg::ADDR_W'(corner);
    end else begin
      acc_addr = vna_pkg::ADDR_W'(in_data_i.corner_a);
    end
  end

  vna_ram #(.WIDTH(vna_pkg::POS_RAM_W), .DEPTH(vna_pkg::VERTEX_SLOTS)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .addr_i (pos_addr),
    .wdata_i(pos_wdata),
    .rdata_o(pos_rdata)
  );

  vna_ram #(.WIDTH(vna_pkg::ACC_RAM_W), .DEPTH(vna_pkg::VERTEX_SLOTS)) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (acc_we),
    .addr_i (acc_addr),
    .wdata_i(acc_wdata),
    .rdata_o(acc_rdata)
  );

  // Cross product of the edges from corner a to corners b and c
  assign cross_start = (state_q == ST_TCAP);

  vna_cross u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cross_start),
    .pa_i   (pa_q),
    .pb_i   (pb_q),
    .pc_i   (pc),
    .cr_o   (cr),
    .done_o (cross_done)
  );

  // Shared normalise unit: triangle normal or accumulated sum
  always_comb begin
    norm_start = ((state_q == ST_CROSS) && cross_done) || ((state_q == ST_QRD) && qin_q);
    for (int i = 0; i < 3; i++) begin
      if (state_q == ST_QRD) begin
        norm_vec[i] = vna_pkg::NIN_W'(acc_old[i]);
      end else begin
        norm_vec[i] = vna_pkg::NIN_W'(cr[i]);
      end
    end
  end

  vna_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start),
    .vec_i  (norm_vec),
    .unit_o (unit),
    .stat_o (nstat)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data_i.operation)
              vna_pkg::OP_TRI:   state_q <= ST_TRD_B;
              vna_pkg::OP_QUERY: state_q <= ST_QRD;
              default:           state_q <= ST_IDLE;
            endcase
          end
        end
        ST_TRD_B: state_q <= (a_ok && b_ok && c_ok) ? ST_TRD_C : ST_IDLE;
        ST_TRD_C: state_q <= ST_TCAP;
        ST_TCAP:  state_q <= ST_CROSS;
        ST_CROSS: begin
          if (cross_done) begin
            state_q <= ST_TNORM;
          end
        end
        ST_TNORM: begin
          if (nstat.done) begin
            cidx_q  <= '0;
            state_q <= ST_ACC_RD;
          end
        end
        ST_ACC_RD: state_q <= ST_ACC_WR;
        ST_ACC_WR: begin
          if (cidx_q == 2'd2) begin
            state_q <= ST_IDLE;
          end else begin
            cidx_q  <= cidx_q + 2'd1;
            state_q <= ST_ACC_RD;
          end
        end
        ST_QRD:   state_q <= qin_q ? ST_QNORM : ST_QOUT;
        ST_QNORM: begin
          if (nstat.done) begin
            state_q <= ST_QOUT;
          end
        end
        ST_QOUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item, corner positions and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      qin_q  <= ia_ok;
    end
    if (state_q == ST_TRD_B) begin
      pa_q <= pc;
    end
    if (state_q == ST_TRD_C) begin
      pb_q <= pc;
    end
    if (state_q == ST_QOUT && !out_valid_q) begin
      out_q.vertex_slot <= item_q.corner_a;
      if (qin_q) begin
        out_q.normal_x     <= unit[0];
        out_q.normal_y     <= unit[1];
        out_q.normal_z     <= unit[2];
        out_q.normal_valid <= nstat.nonzero;
      end else begin
        out_q.normal_x     <= '0;
        out_q.normal_y     <= '0;
        out_q.normal_z     <= '0;
        out_q.normal_valid <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The normalise unit only finishes while the sequencer waits for it
  a_norm_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nstat.done |-> (state_q == ST_TNORM || state_q == ST_QNORM))
    else $error("normalise finished outside a wait state");

  // Accumulator writes come from a load transfer or a corner update only
  a_acc_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> (state_q == ST_ACC_WR || accept))
    else $error("unexpected accumulator write");

  // A finished query always reaches the output register
  a_query_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QOUT && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("query result not presented");
`endif

endmodule
